// ----- rtl/buddy_allocator_top_macros.svh -----
// assertion macros for the buddy allocator
`ifndef BUDDY_ALLOCATOR_TOP_MACROS_SVH
`define BUDDY_ALLOCATOR_TOP_MACROS_SVH

// clocked assertion, held off during reset
`define BUD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define BUD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/bud_alloc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bud_alloc_pkg
// Types and constants shared by the buddy allocator modules.
// ----------------------------------------------------------------------------
package bud_alloc_pkg;

   localparam int TOTAL_SIZE  = 2048;
   localparam int TREE_LEVELS = 12;
   localparam int NODE_COUNT  = (1 << TREE_LEVELS) - 1;
   localparam int IDX_W       = TREE_LEVELS;
   localparam int DEPTH_W     = 4;
   localparam int POS_W       = TREE_LEVELS - 1;
   localparam int AMT_W       = 12;
   localparam int OFF_W       = 11;
   localparam int STAT_W      = 3;

   typedef enum logic [1:0] {
      KIND_ABSENT = 2'd0,
      KIND_FREE   = 2'd1,
      KIND_USED   = 2'd2,
      KIND_SPLIT  = 2'd3
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 3'd0,
      ST_SHORT    = 3'd1,
      ST_FRAG     = 3'd2,
      ST_NO_MATCH = 3'd3,
      ST_ZERO     = 3'd4
   } status_type;

   typedef struct packed {
      logic              kind_we;
      logic              amt_we;
      logic [IDX_W-1:0]  addr;
      kind_type          kind;
      logic [AMT_W-1:0]  amount;
   } mem_wr_type;

   // flat node index of the node at a given depth and position in its level
   function automatic logic [IDX_W-1:0] node_index(logic [DEPTH_W-1:0] depth,
                                                   logic [POS_W-1:0] pos);
      logic [IDX_W-1:0] base;
      base = (IDX_W'(1) << depth) - IDX_W'(1);
      return base + IDX_W'(pos);
   endfunction

endpackage

// ----- rtl/bud_alloc_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bud_alloc_mem
// Node kind and leaf amount stores, one write and one registered read port.
// ----------------------------------------------------------------------------
module bud_alloc_mem (
   input  logic                           clock,
   input  bud_alloc_pkg::mem_wr_type      wr,
   input  logic [bud_alloc_pkg::IDX_W-1:0] raddr,
   output bud_alloc_pkg::kind_type        rkind,
   output logic [bud_alloc_pkg::AMT_W-1:0] ramt
);
   import bud_alloc_pkg::*;

   kind_type         kind_mem [NODE_COUNT];
   logic [AMT_W-1:0] amt_mem  [NODE_COUNT];

   always_ff @(posedge clock) begin
      if (wr.kind_we) begin
         kind_mem[wr.addr] <= wr.kind;
      end
      rkind <= kind_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (wr.amt_we) begin
         amt_mem[wr.addr] <= wr.amount;
      end
      ramt <= amt_mem[raddr];
   end

endmodule

// ----- rtl/buddy_allocator_top.sv -----
`timescale 1ns / 1ps
// zero-size and short-of-memory words are answered without a tree walk; other words run a
// depth-first walk over the tree nodes, climbing back levels as needed, and split levels
// on allocation or merge levels on release
// throughput: one word at a time, busy stays high until the result strobe
// reset: after reset the root is written free in the init state, then busy drops
// results are strobed for one cycle; the receiver cannot stall
// ----------------------------------------------------------------------------
// buddy_allocator_top
// Binary buddy allocator walking a node tree held in a store with one write and one read port.
// ----------------------------------------------------------------------------
module buddy_allocator_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_type,
   input  logic [bud_alloc_pkg::AMT_W-1:0]  req_amount,
   output logic                             rsp_valid,
   output logic [bud_alloc_pkg::STAT_W-1:0] rsp_status,
   output logic [bud_alloc_pkg::OFF_W-1:0]  rsp_block_offset,
   output logic [bud_alloc_pkg::AMT_W-1:0]  rsp_block_size
);
   import bud_alloc_pkg::*;

   typedef enum logic [10:0] {
      S_INIT   = 11'b00000000001,
      S_IDLE   = 11'b00000000010,
      S_PREP   = 11'b00000000100,
      S_RD     = 11'b00000001000,
      S_EV     = 11'b00000010000,
      S_BACK   = 11'b00000100000,
      S_SPLITR = 11'b00001000000,
      S_SPLITL = 11'b00010000000,
      S_MRD    = 11'b00100000000,
      S_MEV    = 11'b01000000000,
      S_RESP   = 11'b10000000000
   } state_type;

   state_type           state_ff, state_in;
   logic                rel_ff, rel_in;
   logic [AMT_W-1:0]    amt_ff, amt_in;
   logic [AMT_W-1:0]    free_ff, free_in;
   logic [DEPTH_W-1:0]  tgt_ff, tgt_in;
   logic [DEPTH_W-1:0]  dep_ff, dep_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic                rv_ff, rv_in;
   status_type          st_ff, st_in;
   logic [OFF_W-1:0]    off_ff, off_in;
   logic [AMT_W-1:0]    size_ff, size_in;

   mem_wr_type          wr;
   logic [IDX_W-1:0]    raddr;
   kind_type            rkind;
   logic [AMT_W-1:0]    ramt;
   logic [IDX_W-1:0]    cur_idx;
   logic [DEPTH_W-1:0]  fit_depth;
   logic [OFF_W-1:0]    cur_off;
   logic [AMT_W-1:0]    cur_size;

   bud_alloc_mem u_mem (
      .clock (clock),
      .wr    (wr),
      .raddr (raddr),
      .rkind (rkind),
      .ramt  (ramt)
   );

   assign cur_idx  = node_index(dep_ff, pos_ff);
   assign cur_off  = OFF_W'(pos_ff) << (DEPTH_W'(POS_W) - dep_ff);
   assign cur_size = AMT_W'(TOTAL_SIZE) >> dep_ff;

   // deepest level whose block still holds the word
   always_comb begin
      fit_depth = '0;
      for (int d = 1; d < TREE_LEVELS; d++) begin
         if ({1'b0, amt_ff} <= (13'(TOTAL_SIZE) >> d)) begin
            fit_depth = fit_depth + DEPTH_W'(1);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      rel_in   = rel_ff;
      amt_in   = amt_ff;
      free_in  = free_ff;
      tgt_in   = tgt_ff;
      dep_in   = dep_ff;
      pos_in   = pos_ff;
      rv_in    = 1'b0;
      st_in    = st_ff;
      off_in   = off_ff;
      size_in  = size_ff;
      wr       = '{kind_we: 1'b0, amt_we: 1'b0, addr: cur_idx, kind: KIND_FREE,
                   amount: amt_ff};
      raddr    = cur_idx;

      unique case (state_ff)
         S_INIT: begin
            wr.kind_we = 1'b1;
            wr.addr    = '0;
            wr.kind    = KIND_FREE;
            state_in   = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               rel_in   = req_type;
               amt_in   = req_amount;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            dep_in  = '0;
            pos_in  = '0;
            tgt_in  = fit_depth;
            off_in  = '0;
            size_in = '0;
            priority if (amt_ff == '0) begin
               st_in    = ST_ZERO;
               state_in = S_RESP;
            end else if (!rel_ff && (amt_ff > free_ff)) begin
               st_in    = ST_SHORT;
               state_in = S_RESP;
            end else begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_EV;
         end
         S_EV: begin
            state_in = S_BACK;
            if (!rel_ff) begin
               priority if (rkind == KIND_FREE && dep_ff == tgt_ff) begin
                  wr.kind_we = 1'b1;
                  wr.amt_we  = 1'b1;
                  wr.kind    = KIND_USED;
                  free_in    = free_ff - amt_ff;
                  st_in      = ST_OK;
                  off_in     = cur_off;
                  size_in    = cur_size;
                  state_in   = S_RESP;
               end else if (rkind == KIND_FREE) begin
                  wr.kind_we = 1'b1;
                  wr.kind    = KIND_SPLIT;
                  dep_in     = dep_ff + DEPTH_W'(1);
                  pos_in     = pos_ff << 1;
                  state_in   = S_SPLITR;
               end else if (rkind == KIND_SPLIT && dep_ff < tgt_ff) begin
                  dep_in   = dep_ff + DEPTH_W'(1);
                  pos_in   = pos_ff << 1;
                  state_in = S_RD;
               end else begin
                  state_in = S_BACK;
               end
            end else begin
               priority if (rkind == KIND_USED && ramt == amt_ff) begin
                  wr.kind_we = 1'b1;
                  wr.kind    = KIND_FREE;
                  free_in    = free_ff + amt_ff;
                  st_in      = ST_OK;
                  off_in     = cur_off;
                  size_in    = cur_size;
                  state_in   = S_MRD;
               end else if (rkind == KIND_SPLIT &&
                            dep_ff < DEPTH_W'(TREE_LEVELS - 1)) begin
                  dep_in   = dep_ff + DEPTH_W'(1);
                  pos_in   = pos_ff << 1;
                  state_in = S_RD;
               end else begin
                  state_in = S_BACK;
               end
            end
         end
         S_BACK: begin
            priority if (dep_ff == '0) begin
               st_in    = rel_ff ? ST_NO_MATCH : ST_FRAG;
               state_in = S_RESP;
            end else if (pos_ff[0]) begin
               dep_in = dep_ff - DEPTH_W'(1);
               pos_in = pos_ff >> 1;
            end else begin
               pos_in   = pos_ff + POS_W'(1);
               state_in = S_RD;
            end
         end
         S_SPLITR: begin
            // right half of a fresh split starts out free
            wr.kind_we = 1'b1;
            wr.addr    = node_index(dep_ff, pos_ff | POS_W'(1));
            wr.kind    = KIND_FREE;
            state_in   = S_SPLITL;
         end
         S_SPLITL: begin
            wr.kind_we = 1'b1;
            if (dep_ff == tgt_ff) begin
               wr.amt_we = 1'b1;
               wr.kind   = KIND_USED;
               free_in   = free_ff - amt_ff;
               st_in     = ST_OK;
               off_in    = cur_off;
               size_in   = cur_size;
               state_in  = S_RESP;
            end else begin
               wr.kind  = KIND_SPLIT;
               dep_in   = dep_ff + DEPTH_W'(1);
               pos_in   = pos_ff << 1;
               state_in = S_SPLITR;
            end
         end
         S_MRD: begin
            raddr = node_index(dep_ff, pos_ff ^ POS_W'(1));
            if (dep_ff == '0) begin
               state_in = S_RESP;
            end else begin
               state_in = S_MEV;
            end
         end
         S_MEV: begin
            if (rkind == KIND_FREE) begin
               wr.kind_we = 1'b1;
               wr.addr    = node_index(dep_ff - DEPTH_W'(1), pos_ff >> 1);
               wr.kind    = KIND_FREE;
               dep_in     = dep_ff - DEPTH_W'(1);
               pos_in     = pos_ff >> 1;
               state_in   = S_MRD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            rv_in    = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         rv_ff    <= 1'b0;
         free_ff  <= AMT_W'(TOTAL_SIZE);
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         free_ff  <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      rel_ff  <= rel_in;
      amt_ff  <= amt_in;
      tgt_ff  <= tgt_in;
      dep_ff  <= dep_in;
      pos_ff  <= pos_in;
      st_ff   <= st_in;
      off_ff  <= off_in;
      size_ff <= size_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rv_ff;
   assign rsp_status       = st_ff;
   assign rsp_block_offset = off_ff;
   assign rsp_block_size   = size_ff;

`include "buddy_allocator_top_macros.svh"

   `BUD_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted word did not raise busy")
   `BUD_ASSERT(a_rsp_after_busy, rsp_valid |-> $past(busy), "result without a word in flight")
   `BUD_ASSERT(a_ok_size, (rsp_valid && rsp_status == ST_OK) |-> (rsp_block_size != '0), "granted block has no size")
   `BUD_ASSERT_ALWAYS(a_state_onehot, reset || $onehot(state_ff), "sequencer state not one-hot")

endmodule

// ----- dv/bud_alloc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bud_alloc_checker
// Watches the request and result channels of the buddy allocator, keeps its
// own copy of the block tree, predicts every result and compares field by field.
// ----------------------------------------------------------------------------
module bud_alloc_checker
   import bud_alloc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic              req_type,
   input  logic [AMT_W-1:0]  req_amount,
   input  logic              rsp_valid,
   input  logic [STAT_W-1:0] rsp_status,
   input  logic [OFF_W-1:0]  rsp_block_offset,
   input  logic [AMT_W-1:0]  rsp_block_size,
   output int                fail_count,
   output int                pending_words
);

   typedef struct {
      status_type        status;
      logic [OFF_W-1:0]  offset;
      logic [AMT_W-1:0]  size;
   } grant_type;

   kind_type          tree_kind [NODE_COUNT];
   logic [AMT_W-1:0]  held_amt  [NODE_COUNT];
   int unsigned       free_units;
   grant_type         grant_q[$];

   function automatic void clear_tree();
      for (int i = 0; i < NODE_COUNT; i++) begin
         tree_kind[i] = KIND_ABSENT;
         held_amt[i]  = '0;
      end
      tree_kind[0] = KIND_FREE;
      free_units   = TOTAL_SIZE;
   endfunction

   // returns node index + 1 of the granted leaf, 0 if none
   function automatic int take_node(int idx, int depth, int want);
      int sz;
      int got;
      if (idx >= NODE_COUNT) return 0;
      sz = TOTAL_SIZE >> depth;
      if (want > sz) return 0;
      if (want > sz / 2 || depth + 1 >= TREE_LEVELS) begin
         if (tree_kind[idx] == KIND_FREE) begin
            tree_kind[idx] = KIND_USED;
            held_amt[idx]  = AMT_W'(want);
            return idx + 1;
         end
         return 0;
      end
      if (tree_kind[idx] == KIND_FREE) begin
         tree_kind[idx]         = KIND_SPLIT;
         tree_kind[2 * idx + 1] = KIND_FREE;
         tree_kind[2 * idx + 2] = KIND_FREE;
      end
      if (tree_kind[idx] != KIND_SPLIT) return 0;
      got = take_node(2 * idx + 1, depth + 1, want);
      if (got != 0) return got;
      return take_node(2 * idx + 2, depth + 1, want);
   endfunction

   function automatic int find_held(int idx, int depth, int amt);
      int got;
      if (idx >= NODE_COUNT) return 0;
      if (tree_kind[idx] == KIND_USED) return (held_amt[idx] == amt) ? idx + 1 : 0;
      if (tree_kind[idx] != KIND_SPLIT || depth + 1 >= TREE_LEVELS) return 0;
      got = find_held(2 * idx + 1, depth + 1, amt);
      if (got != 0) return got;
      return find_held(2 * idx + 2, depth + 1, amt);
   endfunction

   function automatic void place(int idx, ref grant_type g);
      int d;
      int n;
      int sz;
      d = 0;
      n = idx + 1;
      while ((n >> 1) != 0) begin
         n = n >> 1;
         d++;
      end
      sz       = TOTAL_SIZE >> d;
      g.size   = AMT_W'(sz);
      g.offset = OFF_W'((idx + 1 - (1 << d)) * sz);
   endfunction

   function automatic void merge_buddies(int idx);
      int parent;
      while (idx > 0) begin
         parent = (idx - 1) / 2;
         if (tree_kind[2 * parent + 1] != KIND_FREE ||
             tree_kind[2 * parent + 2] != KIND_FREE)
            break;
         tree_kind[parent]         = KIND_FREE;
         tree_kind[2 * parent + 1] = KIND_ABSENT;
         tree_kind[2 * parent + 2] = KIND_ABSENT;
         idx = parent;
      end
   endfunction

   function automatic grant_type predict_grant(logic rel, int amt);
      grant_type g;
      int hit;
      g.status = ST_OK;
      g.offset = '0;
      g.size   = '0;
      if (amt == 0) begin
         g.status = ST_ZERO;
      end else if (!rel) begin
         if (amt > free_units) begin
            g.status = ST_SHORT;
         end else begin
            hit = take_node(0, 0, amt);
            if (hit == 0) begin
               g.status = ST_FRAG;
            end else begin
               free_units -= amt;
               place(hit - 1, g);
            end
         end
      end else begin
         hit = find_held(0, 0, amt);
         if (hit == 0) begin
            g.status = ST_NO_MATCH;
         end else begin
            tree_kind[hit - 1] = KIND_FREE;
            held_amt[hit - 1]  = '0;
            free_units += amt;
            place(hit - 1, g);
            merge_buddies(hit - 1);
         end
      end
      return g;
   endfunction

   always @(posedge clock) begin
      grant_type exp_g;
      if (reset) begin
         clear_tree();
         grant_q.delete();
      end else begin
         if (start && !busy) grant_q.push_back(predict_grant(req_type, int'(req_amount)));
         if (rsp_valid) begin
            if (grant_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result word status=%0d offset=%0d size=%0d",
                           $realtime, rsp_status, rsp_block_offset, rsp_block_size);
            end else begin
               exp_g = grant_q.pop_front();
               if (rsp_status !== exp_g.status || rsp_block_offset !== exp_g.offset ||
                   rsp_block_size !== exp_g.size) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t: mismatch expected status=%0d offset=%0d size=%0d,",
                               " got %0d %0d %0d"},
                              $realtime, exp_g.status, exp_g.offset, exp_g.size,
                              rsp_status, rsp_block_offset, rsp_block_size);
               end
            end
         end
      end
      pending_words <= grant_q.size();
   end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Buddy allocator testbench: directed corner words, then random allocate and
// release traffic with drain phases; checking is done by bud_alloc_checker.
// ----------------------------------------------------------------------------
module tb;
   import bud_alloc_pkg::*;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_type;
   logic [AMT_W-1:0]  req_amount;
   logic              rsp_valid;
   logic [STAT_W-1:0] rsp_status;
   logic [OFF_W-1:0]  rsp_block_offset;
   logic [AMT_W-1:0]  rsp_block_size;
   int                fail_count;
   int                pending_words;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // amounts currently granted, and words still waiting for their result
   int   held[$];
   logic sent_op[$];
   int   sent_amt[$];
   bit   no_gaps;

   buddy_allocator_top DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_amount(req_amount),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_block_offset(rsp_block_offset), .rsp_block_size(rsp_block_size)
   );

   bud_alloc_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_amount(req_amount),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_block_offset(rsp_block_offset), .rsp_block_size(rsp_block_size),
      .fail_count(fail_count), .pending_words(pending_words)
   );

   always begin
      clock = 1'b0; #2;
      clock = 1'b1; #2;
   end

   // track granted amounts so releases mostly hit something
   always @(posedge clock) begin
      logic op;
      int   amt;
      if (!reset) begin
         if (start && !busy) begin
            sent_op.push_back(req_type);
            sent_amt.push_back(int'(req_amount));
         end
         if (rsp_valid && sent_op.size() > 0) begin
            op  = sent_op.pop_front();
            amt = sent_amt.pop_front();
            if (rsp_status == ST_OK) begin
               if (op == OP_ALLOC) begin
                  held.push_back(amt);
               end else begin
                  foreach (held[i]) begin
                     if (held[i] == amt) begin
                        held.delete(i);
                        break;
                     end
                  end
               end
            end
         end
      end
   end

   task automatic issue(logic op, int amt);
      int gap;
      int r;
      r = $urandom_range(99);
      if (no_gaps || r < 55) gap = 0;
      else if (r < 90) gap = $urandom_range(3, 1);
      else gap = $urandom_range(60, 10);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start      <= 1'b1;
      req_type   <= op;
      req_amount <= AMT_W'(amt);
      do @(posedge clock); while (busy);
   endtask

   task automatic drain_all();
      int snap[$];
      start <= 1'b0;
      while (sent_op.size() != 0) @(posedge clock);
      snap = held;
      foreach (snap[i]) issue(OP_RELEASE, snap[i]);
   endtask

   function automatic int pick_amount();
      int r;
      r = $urandom_range(99);
      if (r < 3) return 0;
      if (r < 70) return $urandom_range(64, 1);
      if (r < 90) return $urandom_range(512, 65);
      return $urandom_range(TOTAL_SIZE, 513);
   endfunction

   initial begin
      no_gaps = 1'b0;
      reset      = 1'b1;
      start      = 1'b0;
      req_type   = OP_ALLOC;
      req_amount = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // zero sizes, whole memory, short of memory, deepest level, fragmentation
      issue(OP_ALLOC, 0);
      issue(OP_RELEASE, 0);
      issue(OP_ALLOC, TOTAL_SIZE);
      issue(OP_ALLOC, 1);
      issue(OP_RELEASE, TOTAL_SIZE);
      issue(OP_ALLOC, 1);
      issue(OP_ALLOC, 1);
      issue(OP_ALLOC, 2);
      issue(OP_RELEASE, 7);
      issue(OP_ALLOC, 1100);
      issue(OP_RELEASE, 1);
      issue(OP_RELEASE, 1);
      issue(OP_RELEASE, 2);
      issue(OP_ALLOC, 2047);
      issue(OP_RELEASE, 2047);
      issue(OP_ALLOC, 1024);
      issue(OP_ALLOC, 1023);
      issue(OP_ALLOC, 1);
      issue(OP_RELEASE, 1024);
      issue(OP_RELEASE, 1023);
      issue(OP_ALLOC, 1365);
      issue(OP_ALLOC, 682);
      issue(OP_RELEASE, 1365);
      issue(OP_RELEASE, 682);

      for (int phase = 0; phase < 5; phase++) begin
         no_gaps = (phase == 2);
         for (int n = 0; n < 260; n++) begin
            if ($urandom_range(99) < 58) begin
               issue(OP_ALLOC, pick_amount());
            end else if (held.size() > 0 && $urandom_range(99) < 85) begin
               issue(OP_RELEASE, held[$urandom_range(held.size() - 1)]);
            end else begin
               issue(OP_RELEASE, pick_amount());
            end
         end
         drain_all();
      end

      start <= 1'b0;
      while (pending_words != 0 || sent_op.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin
      #1_000_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
